[design/cpt_pkg.sv]
// Shared widths, stage numbers, region codes and types for the closest-point pipeline.
package cpt_pkg;

    localparam int CW   = 24;
    localparam int F    = 16;

    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 2;
    localparam int LOW  = DOTW / 2;
    localparam int HIW  = DOTW - LOW;
    localparam int XW   = 2 * DOTW;
    localparam int NW   = XW + 2;
    localparam int WW   = F + 1;
    localparam int BPW  = CW + WW + 1;
    localparam int BW   = CW + WW + 3;

    localparam logic [WW-1:0] ONE = WW'(1) << F;

    localparam int S_IN  = 0;
    localparam int S_DIF = 1;
    localparam int S_PRD = 2;
    localparam int S_DOT = 3;
    localparam int S_PAR = 4;
    localparam int S_CRS = 5;
    localparam int S_BAR = 6;
    localparam int S_SEL = 7;
    localparam int S_NRM = 8;
    localparam int S_CHK = 9;
    localparam int S_DIV = 10;
    localparam int S_WGT = S_DIV + F;
    localparam int S_BLP = S_WGT + 1;
    localparam int S_BLS = S_WGT + 2;
    localparam int S_OUT = S_WGT + 3;
    localparam int NS    = S_OUT + 1;

    localparam logic [2:0] RG_VA = 3'd0;
    localparam logic [2:0] RG_VB = 3'd1;
    localparam logic [2:0] RG_VC = 3'd2;
    localparam logic [2:0] RG_AB = 3'd3;
    localparam logic [2:0] RG_AC = 3'd4;
    localparam logic [2:0] RG_BC = 3'd5;
    localparam logic [2:0] RG_IN = 3'd6;

    typedef logic [2:0][CW-1:0] t_vec;

    typedef struct packed {
        t_vec p;
        t_vec a;
        t_vec b;
        t_vec c;
    } t_tri;

    typedef struct packed {
        logic v_a;
        logic v_b;
        logic v_c;
        logic g_ab;
        logic g_ac;
        logic g_bc;
    } t_flg;

endpackage

[design/closest_point_on_triangle.sv]
// Closest point on a triangle: pipelined Voronoi region test, barycentric weights and blend.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  in      | i_in_valid / o_in_ready    | i_query_*, i_vert_a_*, i_vert_b_*, i_vert_c_*
//  out     | o_out_valid / i_out_ready  | o_weight_a/b/c, o_near_x/y/z, o_region
//
// One transfer per cycle in and out while the output side is not stalled; the restoring
// divider produces one quotient bit per stage, in two lanes.
// Wide cross products are split into four partial products and summed a stage later.
// Synchronous active-low reset clears the valid bits only.
// A full stage holds while the stage after it is full and stalled; bubbles are filled.
module closest_point_on_triangle (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [cpt_pkg::CW-1:0]   i_query_x,
    input  logic signed [cpt_pkg::CW-1:0]   i_query_y,
    input  logic signed [cpt_pkg::CW-1:0]   i_query_z,
    input  logic signed [cpt_pkg::CW-1:0]   i_vert_a_x,
    input  logic signed [cpt_pkg::CW-1:0]   i_vert_a_y,
    input  logic signed [cpt_pkg::CW-1:0]   i_vert_a_z,
    input  logic signed [cpt_pkg::CW-1:0]   i_vert_b_x,
    input  logic signed [cpt_pkg::CW-1:0]   i_vert_b_y,
    input  logic signed [cpt_pkg::CW-1:0]   i_vert_b_z,
    input  logic signed [cpt_pkg::CW-1:0]   i_vert_c_x,
    input  logic signed [cpt_pkg::CW-1:0]   i_vert_c_y,
    input  logic signed [cpt_pkg::CW-1:0]   i_vert_c_z,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic        [cpt_pkg::WW-1:0]   o_weight_a,
    output logic        [cpt_pkg::WW-1:0]   o_weight_b,
    output logic        [cpt_pkg::WW-1:0]   o_weight_c,
    output logic signed [cpt_pkg::CW-1:0]   o_near_x,
    output logic signed [cpt_pkg::CW-1:0]   o_near_y,
    output logic signed [cpt_pkg::CW-1:0]   o_near_z,
    output logic        [2:0]               o_region
);
    import cpt_pkg::*;

    localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PY [6] = '{3, 1, 1, 5, 5, 3};
    localparam logic signed [BW-1:0] RND  = BW'(1) <<< (F - 1);
    localparam logic signed [BW-1:0] SMAX = (BW'(1) <<< (CW - 1)) - BW'(1);
    localparam logic signed [BW-1:0] SMIN = -SMAX - BW'(1);

    logic [NS-1:0] r_vld;
    logic [NS-1:0] ld;

    t_tri                      r_tri [S_IN:S_WGT];
    logic signed [DW-1:0]      r_ab [3], r_ac [3], r_ap [3], r_bp [3], r_cp [3];
    logic signed [PW-1:0]      r_pr [6][3];
    logic signed [DOTW-1:0]    r_d [S_DOT:S_BAR][6];
    logic signed [DOTW:0]      r_e43 [S_PAR:S_BAR];
    logic signed [DOTW:0]      r_e56 [S_PAR:S_BAR];
    t_flg                      r_fl [S_PAR:S_BAR];
    logic signed [2*HIW-1:0]   r_hh [6];
    logic signed [HIW+LOW:0]   r_hl [6], r_lh [6];
    logic signed [2*LOW+1:0]   r_ll [6];
    logic signed [XW-1:0]      r_x [6];
    logic signed [NW-1:0]      r_v [3];
    logic signed [NW-1:0]      r_sn [2], r_sd [2], r_nn [2], r_nd [2];
    logic [2:0]                r_rg [S_SEL:S_OUT];
    logic [NW-1:0]             r_rm [2][S_CHK:S_WGT-1];
    logic [NW-1:0]             r_dv [2][S_CHK:S_WGT-1];
    logic [F-1:0]              r_q [2][S_CHK:S_WGT-1];
    logic                      r_zro [2][S_CHK:S_WGT-1];
    logic                      r_ful [2][S_CHK:S_WGT-1];
    logic [WW-1:0]             r_w [S_WGT:S_OUT][3];
    logic signed [BPW-1:0]     r_bl [3][3];
    logic signed [BW-1:0]      r_s [3];
    logic signed [CW-1:0]      r_nr [3];

    logic signed [HIW-1:0]     xh [6], yh [6];
    logic signed [LOW:0]       xl [6], yl [6];
    t_flg                      n_fl;
    logic [2:0]                n_rg;
    logic signed [NW-1:0]      n_sn [2], n_sd [2];
    logic [NW-1:0]             n_rm [2][S_DIV:S_WGT-1];
    logic [F-1:0]              n_q [2][S_DIV:S_WGT-1];
    logic [NW-1:0]             sh [2][S_DIV:S_WGT-1];
    logic [WW-1:0]             t [2];
    logic [WW-1:0]             n_w [3];
    logic [WW:0]               tsum;
    logic signed [BW-1:0]      n_s [3];

    // stage load enables: a stage loads when empty or when its content moves on
    always_comb begin
        ld[S_OUT] = !r_vld[S_OUT] || i_out_ready;
        for (int k = S_OUT - 1; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_in_ready = ld[S_IN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // input capture and vertex carry
    always_ff @(posedge i_clk) begin
        if (ld[S_IN]) begin
            r_tri[S_IN].p <= {i_query_z, i_query_y, i_query_x};
            r_tri[S_IN].a <= {i_vert_a_z, i_vert_a_y, i_vert_a_x};
            r_tri[S_IN].b <= {i_vert_b_z, i_vert_b_y, i_vert_b_x};
            r_tri[S_IN].c <= {i_vert_c_z, i_vert_c_y, i_vert_c_x};
        end
        for (int k = S_IN + 1; k <= S_WGT; k++) begin
            if (ld[k]) begin
                r_tri[k] <= r_tri[k-1];
            end
        end
    end

    // edge and offset vectors, the eighteen products, then the six dot sums and their carry
    always_ff @(posedge i_clk) begin
        if (ld[S_DIF]) begin
            for (int k = 0; k < 3; k++) begin
                r_ab[k] <= DW'($signed(r_tri[S_IN].b[k])) - DW'($signed(r_tri[S_IN].a[k]));
                r_ac[k] <= DW'($signed(r_tri[S_IN].c[k])) - DW'($signed(r_tri[S_IN].a[k]));
                r_ap[k] <= DW'($signed(r_tri[S_IN].p[k])) - DW'($signed(r_tri[S_IN].a[k]));
                r_bp[k] <= DW'($signed(r_tri[S_IN].p[k])) - DW'($signed(r_tri[S_IN].b[k]));
                r_cp[k] <= DW'($signed(r_tri[S_IN].p[k])) - DW'($signed(r_tri[S_IN].c[k]));
            end
        end
        if (ld[S_PRD]) begin
            for (int k = 0; k < 3; k++) begin
                r_pr[0][k] <= r_ab[k] * r_ap[k];
                r_pr[1][k] <= r_ac[k] * r_ap[k];
                r_pr[2][k] <= r_ab[k] * r_bp[k];
                r_pr[3][k] <= r_ac[k] * r_bp[k];
                r_pr[4][k] <= r_ab[k] * r_cp[k];
                r_pr[5][k] <= r_ac[k] * r_cp[k];
            end
        end
        if (ld[S_DOT]) begin
            for (int j = 0; j < 6; j++) begin
                r_d[S_DOT][j] <= DOTW'(r_pr[j][0]) + DOTW'(r_pr[j][1]) + DOTW'(r_pr[j][2]);
            end
        end
        for (int k = S_DOT + 1; k <= S_BAR; k++) begin
            if (ld[k]) begin
                r_d[k] <= r_d[k-1];
            end
        end
    end

    // operand halves for the split cross products, and region tests on the dots
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            xh[i] = $signed(r_d[S_DOT][PX[i]][DOTW-1:LOW]);
            yh[i] = $signed(r_d[S_DOT][PY[i]][DOTW-1:LOW]);
            xl[i] = $signed({1'b0, r_d[S_DOT][PX[i]][LOW-1:0]});
            yl[i] = $signed({1'b0, r_d[S_DOT][PY[i]][LOW-1:0]});
        end
        n_fl.v_a  = (r_d[S_DOT][0] <= 0) && (r_d[S_DOT][1] <= 0);
        n_fl.v_b  = (r_d[S_DOT][2] >= 0) && (r_d[S_DOT][3] <= r_d[S_DOT][2]);
        n_fl.v_c  = (r_d[S_DOT][5] >= 0) && (r_d[S_DOT][4] <= r_d[S_DOT][5]);
        n_fl.g_ab = (r_d[S_DOT][0] >= 0) && (r_d[S_DOT][2] <= 0);
        n_fl.g_ac = (r_d[S_DOT][1] >= 0) && (r_d[S_DOT][5] <= 0);
        n_fl.g_bc = (r_d[S_DOT][3] >= r_d[S_DOT][2]) && (r_d[S_DOT][4] >= r_d[S_DOT][5]);
    end

    always_ff @(posedge i_clk) begin
        if (ld[S_PAR]) begin
            for (int i = 0; i < 6; i++) begin
                r_hh[i] <= xh[i] * yh[i];
                r_hl[i] <= xh[i] * yl[i];
                r_lh[i] <= xl[i] * yh[i];
                r_ll[i] <= xl[i] * yl[i];
            end
            r_fl[S_PAR]  <= n_fl;
            r_e43[S_PAR] <= (DOTW+1)'(r_d[S_DOT][3]) - (DOTW+1)'(r_d[S_DOT][2]);
            r_e56[S_PAR] <= (DOTW+1)'(r_d[S_DOT][4]) - (DOTW+1)'(r_d[S_DOT][5]);
        end
        for (int k = S_PAR + 1; k <= S_BAR; k++) begin
            if (ld[k]) begin
                r_fl[k]  <= r_fl[k-1];
                r_e43[k] <= r_e43[k-1];
                r_e56[k] <= r_e56[k-1];
            end
        end
        if (ld[S_CRS]) begin
            for (int i = 0; i < 6; i++) begin
                r_x[i] <= (XW'(r_hh[i]) <<< (2 * LOW))
                        + ((XW'(r_hl[i]) + XW'(r_lh[i])) <<< LOW)
                        + XW'(r_ll[i]);
            end
        end
        if (ld[S_BAR]) begin
            r_v[0] <= NW'(r_x[4]) - NW'(r_x[5]);
            r_v[1] <= NW'(r_x[2]) - NW'(r_x[3]);
            r_v[2] <= NW'(r_x[0]) - NW'(r_x[1]);
        end
    end

    // region choice and divider operands
    always_comb begin
        n_rg    = RG_IN;
        n_sn[0] = '0;
        n_sd[0] = '0;
        n_sn[1] = '0;
        n_sd[1] = '0;
        if (r_fl[S_BAR].v_a) begin
            n_rg = RG_VA;
        end else if (r_fl[S_BAR].v_b) begin
            n_rg = RG_VB;
        end else if (r_fl[S_BAR].v_c) begin
            n_rg = RG_VC;
        end else if (r_v[2] <= 0 && r_fl[S_BAR].g_ab) begin
            n_rg    = RG_AB;
            n_sn[0] = NW'(r_d[S_BAR][0]);
            n_sd[0] = NW'(r_d[S_BAR][0]) - NW'(r_d[S_BAR][2]);
        end else if (r_v[1] <= 0 && r_fl[S_BAR].g_ac) begin
            n_rg    = RG_AC;
            n_sn[0] = NW'(r_d[S_BAR][1]);
            n_sd[0] = NW'(r_d[S_BAR][1]) - NW'(r_d[S_BAR][5]);
        end else if (r_v[0] <= 0 && r_fl[S_BAR].g_bc) begin
            n_rg    = RG_BC;
            n_sn[0] = NW'(r_e43[S_BAR]);
            n_sd[0] = NW'(r_e43[S_BAR]) + NW'(r_e56[S_BAR]);
        end else begin
            n_sn[0] = r_v[1];
            n_sd[0] = r_v[0] + r_v[1] + r_v[2];
            n_sn[1] = r_v[2];
            n_sd[1] = r_v[0] + r_v[1] + r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[S_SEL]) begin
            r_rg[S_SEL] <= n_rg;
            r_sn        <= n_sn;
            r_sd        <= n_sd;
        end
        for (int k = S_SEL + 1; k <= S_OUT; k++) begin
            if (ld[k]) begin
                r_rg[k] <= r_rg[k-1];
            end
        end
        if (ld[S_NRM]) begin
            for (int l = 0; l < 2; l++) begin
                if (r_sd[l] < 0) begin
                    r_nn[l] <= -r_sn[l];
                    r_nd[l] <= -r_sd[l];
                end else begin
                    r_nn[l] <= r_sn[l];
                    r_nd[l] <= r_sd[l];
                end
            end
        end
        if (ld[S_CHK]) begin
            for (int l = 0; l < 2; l++) begin
                r_zro[l][S_CHK] <= (r_nd[l] == 0) || (r_nn[l] <= 0);
                r_ful[l][S_CHK] <= r_nn[l] >= r_nd[l];
                r_rm[l][S_CHK]  <= r_nn[l];
                r_dv[l][S_CHK]  <= r_nd[l];
                r_q[l][S_CHK]   <= '0;
            end
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int k = S_DIV; k < S_WGT; k++) begin
                sh[l][k] = {r_rm[l][k-1][NW-2:0], 1'b0};
                if (sh[l][k] >= r_dv[l][k-1]) begin
                    n_rm[l][k] = sh[l][k] - r_dv[l][k-1];
                    n_q[l][k]  = {r_q[l][k-1][F-2:0], 1'b1};
                end else begin
                    n_rm[l][k] = sh[l][k];
                    n_q[l][k]  = {r_q[l][k-1][F-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = S_DIV; k < S_WGT; k++) begin
            if (ld[k]) begin
                for (int l = 0; l < 2; l++) begin
                    r_rm[l][k]  <= n_rm[l][k];
                    r_q[l][k]   <= n_q[l][k];
                    r_dv[l][k]  <= r_dv[l][k-1];
                    r_zro[l][k] <= r_zro[l][k-1];
                    r_ful[l][k] <= r_ful[l][k-1];
                end
            end
        end
    end

    // weights per region
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_zro[l][S_WGT-1]) begin
                t[l] = '0;
            end else if (r_ful[l][S_WGT-1]) begin
                t[l] = ONE;
            end else begin
                t[l] = {1'b0, r_q[l][S_WGT-1]};
            end
        end
        tsum   = {1'b0, t[0]} + {1'b0, t[1]};
        n_w[0] = '0;
        n_w[1] = '0;
        n_w[2] = '0;
        case (r_rg[S_WGT-1])
            RG_VA: n_w[0] = ONE;
            RG_VB: n_w[1] = ONE;
            RG_VC: n_w[2] = ONE;
            RG_AB: begin
                n_w[0] = ONE - t[0];
                n_w[1] = t[0];
            end
            RG_AC: begin
                n_w[0] = ONE - t[0];
                n_w[2] = t[0];
            end
            RG_BC: begin
                n_w[1] = ONE - t[0];
                n_w[2] = t[0];
            end
            RG_IN: begin
                n_w[1] = t[0];
                n_w[2] = t[1];
                n_w[0] = (tsum >= {1'b0, ONE}) ? '0 : ONE - t[0] - t[1];
            end
            default: begin
                n_w[0] = '0;
            end
        endcase
    end

    // blend, round half up, saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s[k] = BW'(r_bl[k][0]) + BW'(r_bl[k][1]) + BW'(r_bl[k][2]) + RND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[S_WGT]) begin
            r_w[S_WGT] <= n_w;
        end
        for (int k = S_WGT + 1; k <= S_OUT; k++) begin
            if (ld[k]) begin
                r_w[k] <= r_w[k-1];
            end
        end
        if (ld[S_BLP]) begin
            for (int k = 0; k < 3; k++) begin
                r_bl[k][0] <= $signed(r_tri[S_WGT].a[k]) * $signed({1'b0, r_w[S_WGT][0]});
                r_bl[k][1] <= $signed(r_tri[S_WGT].b[k]) * $signed({1'b0, r_w[S_WGT][1]});
                r_bl[k][2] <= $signed(r_tri[S_WGT].c[k]) * $signed({1'b0, r_w[S_WGT][2]});
            end
        end
        if (ld[S_BLS]) begin
            for (int k = 0; k < 3; k++) begin
                r_s[k] <= n_s[k] >>> F;
            end
        end
        if (ld[S_OUT]) begin
            for (int k = 0; k < 3; k++) begin
                if (r_s[k] > SMAX) begin
                    r_nr[k] <= SMAX[CW-1:0];
                end else if (r_s[k] < SMIN) begin
                    r_nr[k] <= SMIN[CW-1:0];
                end else begin
                    r_nr[k] <= r_s[k][CW-1:0];
                end
            end
        end
    end

    assign o_out_valid = r_vld[S_OUT];
    assign o_weight_a  = r_w[S_OUT][0];
    assign o_weight_b  = r_w[S_OUT][1];
    assign o_weight_c  = r_w[S_OUT][2];
    assign o_near_x    = r_nr[0];
    assign o_near_y    = r_nr[1];
    assign o_near_z    = r_nr[2];
    assign o_region    = r_rg[S_OUT];

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled although the output side can move");

    a_sum_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region != RG_IN)
        |-> ({2'b00, o_weight_a} + {2'b00, o_weight_b} + {2'b00, o_weight_c}
             == {2'b00, ONE}))
        else $error("weights of a boundary region do not sum to one");

    a_vert_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region == RG_VA) |-> (o_weight_a == ONE))
        else $error("vertex a region without full weight on a");

    a_edge_ab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_region == RG_AB) |-> (o_weight_c == '0))
        else $error("edge ab region with weight on c");

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_region <= RG_IN))
        else $error("region code out of range");

endmodule
